[rtl/ship_rrip_replacement_policy_unit_defines.svh]
// Assertion helpers shared by the policy unit RTL.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef SHIP_RRIP_REPLACEMENT_POLICY_UNIT_DEFINES_SVH
`define SHIP_RRIP_REPLACEMENT_POLICY_UNIT_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define SR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset
`define SR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/ship_rrip_pkg.sv]
package ship_rrip_pkg;

  // Request opcodes
  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Re-reference prediction values
  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] RRPV_LONG    = 2'd2;
  localparam logic [1:0] RRPV_DISTANT = 2'd3;

  // Signature counter values
  localparam logic [1:0] CTR_ZERO = 2'd0;
  localparam logic [1:0] CTR_INIT = 2'd1;
  localparam logic [1:0] CTR_MAX  = 2'd3;

  // Program counter width
  localparam int unsigned PC_W = 32;

  // Request transaction
  typedef struct packed {
    logic            op;
    logic [9:0]      set_index;
    logic [3:0]      way;
    logic            hit;
    logic [PC_W-1:0] pc;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic [3:0] victim_way;
    logic       victim_valid;
  } rsp_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_CTR
  } state_e;

endpackage

[rtl/ship_rrip_line_ram.sv]
// Per-set line state: one row holds every way of a set.
module ship_rrip_line_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 272,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ship_rrip_shct_ram.sv]
// Signature counter table: one write port, two registered read ports.
module ship_rrip_shct_ram #(
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [1:0]    rdata_a_o,
  output logic [1:0]    rdata_b_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [1:0]    wdata_i
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_a_q;
  logic [1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/ship_rrip_sig_hash.sv]
// Signature hash: pc modulo the counter table size.
// Power-of-two tables take a registered mask. Otherwise the quotient comes
// from a 33-bit rounded-up reciprocal, exact for every 32-bit pc, and is
// registered; the remainder follows from its low bits.
module ship_rrip_sig_hash #(
  parameter int unsigned SHCT_ENTRIES = 16384,
  localparam int unsigned SIG_W = $clog2(SHCT_ENTRIES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ship_rrip_pkg::PC_W-1:0] pc_i,
  output logic [SIG_W-1:0]              sig_o,
  output logic                          done_o
);

  localparam bit IS_POW2 = ((SHCT_ENTRIES & (SHCT_ENTRIES - 1)) == 0);

  if (IS_POW2) begin : g_mask
    logic             done_q;
    logic [SIG_W-1:0] sig_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else if (start_i) begin
        done_q <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sig_q <= pc_i[SIG_W-1:0];
      end
    end

    assign sig_o  = sig_q;
    assign done_o = done_q;
  end else begin : g_recip
    localparam int unsigned SH     = ship_rrip_pkg::PC_W + SIG_W;
    localparam int unsigned PROD_W = ship_rrip_pkg::PC_W + 33;
    localparam logic [32:0] RECIP  =
      33'(((64'd1 << SH) + 64'(SHCT_ENTRIES) - 64'd1) / 64'(SHCT_ENTRIES));

    logic                           busy_q;
    logic                           done_q;
    logic [ship_rrip_pkg::PC_W-1:0] pc_q;
    logic [SIG_W-1:0]               quo_q;
    logic [PROD_W-1:0]              prod;

    // Quotient by reciprocal multiplication; only its low bits are kept
    assign prod = PROD_W'(pc_q) * PROD_W'(RECIP);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
      end else if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end else if (busy_q) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        pc_q <= pc_i;
      end
      if (busy_q) begin
        quo_q <= prod[SH +: SIG_W];
      end
    end

    // remainder = pc - quotient * size, which fits in SIG_W bits
    assign sig_o  = pc_q[SIG_W-1:0] - quo_q * SIG_W'(SHCT_ENTRIES);
    assign done_o = done_q;
  end

endmodule

[rtl/ship_rrip_replacement_policy_unit.sv]
// SHiP replacement policy for a SETS x WAYS cache. Line state (RRPV, outcome,
// fill signature) sits in a per-set row memory and the signature counters in
// a separate table; both are synchronous with registered reads, and one
// request is in flight at a time. A victim request reads the row, then ages,
// picks and writes it back; an update reads the row, then the counters, then
// writes counter and row back, and a miss fill waits for the signature hash,
// which is a mask for a power-of-two table and otherwise a reciprocal
// multiplication whose quotient is registered before the remainder is formed.
// After reset both memories are cleared, one entry per cycle, over
// max(SETS, SHCT_ENTRIES) entries before the first request is taken. A result
// waiting in the output register does not block the next request from being
// taken and read.
`include "ship_rrip_replacement_policy_unit_defines.svh"

module ship_rrip_replacement_policy_unit #(
  parameter int unsigned SETS         = 1024,
  parameter int unsigned WAYS         = 16,
  parameter int unsigned SHCT_ENTRIES = 16384
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ship_rrip_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ship_rrip_pkg::rsp_t out_data_o
);

  localparam int unsigned SIG_W   = $clog2(SHCT_ENTRIES);
  localparam int unsigned SET_IW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_IW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ENTRY_W = SIG_W + 3;
  localparam int unsigned ROW_W   = WAYS * ENTRY_W;
  localparam int unsigned CLR_N   = (SETS > SHCT_ENTRIES) ? SETS : SHCT_ENTRIES;
  localparam int unsigned CLR_W   = $clog2(CLR_N);

  // Set index reduced modulo SETS by restoring subtraction
  function automatic logic [SET_IW-1:0] set_mod(input logic [9:0] s);
    logic [26:0] r;
    r = 27'(s);
    for (int k = 9; k >= 0; k--) begin
      if (r >= (27'(SETS) << k)) begin
        r = r - (27'(SETS) << k);
      end
    end
    return SET_IW'(r);
  endfunction

  // Way reduced modulo WAYS
  function automatic logic [WAY_IW-1:0] way_mod(input logic [3:0] w);
    logic [10:0] r;
    r = 11'(w);
    for (int k = 3; k >= 0; k--) begin
      if (r >= (11'(WAYS) << k)) begin
        r = r - (11'(WAYS) << k);
      end
    end
    return WAY_IW'(r);
  endfunction

  ship_rrip_pkg::state_e state_q, state_d;

  logic              in_acc;
  logic              line_re, line_we;
  logic              shct_re, shct_we;
  logic              fin_victim, fin_update, fin;
  logic              clr_active;
  logic              out_free;

  logic [CLR_W-1:0]  clr_q;
  logic              clr_last;
  logic              op_q, hit_q;
  logic [SET_IW-1:0] set_q;
  logic [WAY_IW-1:0] way_q;

  logic [ROW_W-1:0]  row_rd;
  logic [ROW_W-1:0]  clr_row, aged_row, upd_row, line_wdata;
  logic [SET_IW-1:0] line_waddr;
  logic [1:0]        ctr_a, ctr_b, ctr_a_new, ctr_s;
  logic [SIG_W-1:0]  shct_waddr;
  logic [1:0]        shct_wdata;

  logic [SIG_W-1:0]  sig;
  logic              sig_done;

  logic [1:0]        rrpv_w [WAYS];
  logic [WAYS-1:0]   is3, is2, is1, top_hit;
  logic [1:0]        top, age_add;
  logic [WAY_IW-1:0] victim_w;

  logic [ENTRY_W-1:0] entry_old, entry_new;
  logic [SIG_W-1:0]   old_sig;
  logic               old_out;

  ship_rrip_pkg::rsp_t out_q, rsp;
  logic                out_valid_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign clr_last = (clr_q == CLR_W'(CLR_N - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ship_rrip_pkg::ST_CLEAR: begin
        if (clr_last) state_d = ship_rrip_pkg::ST_IDLE;
      end
      ship_rrip_pkg::ST_IDLE: begin
        if (in_acc) state_d = ship_rrip_pkg::ST_ROW;
      end
      ship_rrip_pkg::ST_ROW: begin
        if (op_q == ship_rrip_pkg::OP_VICTIM) begin
          if (out_free) state_d = ship_rrip_pkg::ST_IDLE;
        end else if (hit_q || sig_done) begin
          state_d = ship_rrip_pkg::ST_CTR;
        end
      end
      ship_rrip_pkg::ST_CTR: begin
        if (out_free) state_d = ship_rrip_pkg::ST_IDLE;
      end
      default: state_d = ship_rrip_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    line_re    = 1'b0;
    shct_re    = 1'b0;
    fin_victim = 1'b0;
    fin_update = 1'b0;
    clr_active = 1'b0;
    case (state_q)
      ship_rrip_pkg::ST_CLEAR: begin
        clr_active = 1'b1;
      end
      ship_rrip_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        line_re    = in_valid_i;
      end
      ship_rrip_pkg::ST_ROW: begin
        if (op_q == ship_rrip_pkg::OP_VICTIM) begin
          fin_victim = out_free;
        end else begin
          shct_re = hit_q || sig_done;
        end
      end
      ship_rrip_pkg::ST_CTR: begin
        fin_update = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign fin = fin_victim || fin_update;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ship_rrip_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (clr_active && !clr_last) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // Request fields kept for the rest of the transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_data_i.op;
      hit_q <= in_data_i.hit;
      set_q <= set_mod(in_data_i.set_index);
      way_q <= way_mod(in_data_i.way);
    end
  end

  ship_rrip_sig_hash #(
    .SHCT_ENTRIES(SHCT_ENTRIES)
  ) u_sig_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_acc),
    .pc_i   (in_data_i.pc),
    .sig_o  (sig),
    .done_o (sig_done)
  );

  // Victim selection: age the row so its largest RRPV reaches distant
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rrpv_w[w] = row_rd[w*ENTRY_W + SIG_W + 1 +: 2];
      is3[w]    = (rrpv_w[w] == 2'd3);
      is2[w]    = (rrpv_w[w] == 2'd2);
      is1[w]    = (rrpv_w[w] == 2'd1);
    end
    if (|is3)      top = 2'd3;
    else if (|is2) top = 2'd2;
    else if (|is1) top = 2'd1;
    else           top = 2'd0;
    age_add  = ship_rrip_pkg::RRPV_DISTANT - top;
    aged_row = row_rd;
    for (int w = 0; w < WAYS; w++) begin
      aged_row[w*ENTRY_W + SIG_W + 1 +: 2] = rrpv_w[w] + age_add;
      top_hit[w] = (rrpv_w[w] == top);
    end
    // lowest way that ends up distant
    victim_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (top_hit[w]) victim_w = WAY_IW'(w);
    end
  end

  // Update: train the counter of the line's stored signature, then promote the line on a hit or refill it on a miss
  always_comb begin
    entry_old = row_rd[way_q*ENTRY_W +: ENTRY_W];
    old_sig   = entry_old[SIG_W-1:0];
    old_out   = entry_old[SIG_W];
    ctr_s     = ctr_b;
    if (hit_q) begin
      ctr_a_new = (ctr_a == ship_rrip_pkg::CTR_MAX) ? ctr_a : ctr_a + 2'd1;
      entry_new = {ship_rrip_pkg::RRPV_NEAR, 1'b1, old_sig};
    end else begin
      ctr_a_new = (!old_out && ctr_a != ship_rrip_pkg::CTR_ZERO) ? ctr_a - 2'd1 : ctr_a;
      // forward the decrement when the new signature matches the old one
      if (sig == old_sig) ctr_s = ctr_a_new;
      entry_new = {(ctr_s == ship_rrip_pkg::CTR_ZERO) ? ship_rrip_pkg::RRPV_DISTANT
                                                       : ship_rrip_pkg::RRPV_LONG,
                   1'b0, sig};
    end
    upd_row = row_rd;
    upd_row[way_q*ENTRY_W +: ENTRY_W] = entry_new;
  end

  // Reset row image
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      clr_row[w*ENTRY_W +: ENTRY_W] = {ship_rrip_pkg::RRPV_DISTANT, 1'b0, {SIG_W{1'b0}}};
    end
  end

  // Memory write ports: clearing pass or write-back
  always_comb begin
    if (clr_active) begin
      line_we    = ({1'b0, clr_q} < (CLR_W + 1)'(SETS));
      line_waddr = clr_q[SET_IW-1:0];
      line_wdata = clr_row;
      shct_we    = ({1'b0, clr_q} < (CLR_W + 1)'(SHCT_ENTRIES));
      shct_waddr = clr_q[SIG_W-1:0];
      shct_wdata = ship_rrip_pkg::CTR_INIT;
    end else begin
      line_we    = fin;
      line_waddr = set_q;
      line_wdata = fin_victim ? aged_row : upd_row;
      shct_we    = fin_update;
      shct_waddr = old_sig;
      shct_wdata = ctr_a_new;
    end
  end

  ship_rrip_line_ram #(
    .DEPTH(SETS),
    .WIDTH(ROW_W)
  ) u_line_ram (
    .clk_i  (clk_i),
    .re_i   (line_re),
    .raddr_i(set_mod(in_data_i.set_index)),
    .rdata_o(row_rd),
    .we_i   (line_we),
    .waddr_i(line_waddr),
    .wdata_i(line_wdata)
  );

  ship_rrip_shct_ram #(
    .DEPTH(SHCT_ENTRIES)
  ) u_shct_ram (
    .clk_i    (clk_i),
    .re_i     (shct_re),
    .raddr_a_i(old_sig),
    .raddr_b_i(sig),
    .rdata_a_o(ctr_a),
    .rdata_b_o(ctr_b),
    .we_i     (shct_we),
    .waddr_i  (shct_waddr),
    .wdata_i  (shct_wdata)
  );

  // Output register
  always_comb begin
    rsp.victim_way   = fin_victim ? 4'(victim_w) : 4'd0;
    rsp.victim_valid = fin_victim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `SR_ASSERT(a_accept_to_row, in_acc |=> (state_q == ship_rrip_pkg::ST_ROW), "accept did not start a row read")
  `SR_ASSERT(a_fill_sig_ready, (state_q == ship_rrip_pkg::ST_CTR && !hit_q) |-> sig_done, "fill reached counter stage without a signature")
  `SR_NEVER(a_line_rw_clash, line_re && line_we, "line row read and written in one cycle")
  `SR_ASSERT(a_shct_write_state, shct_we |-> (state_q == ship_rrip_pkg::ST_CLEAR || state_q == ship_rrip_pkg::ST_CTR), "counter table written outside clear or write-back")
  `SR_ASSERT(a_victim_found, (state_q == ship_rrip_pkg::ST_ROW && op_q == ship_rrip_pkg::OP_VICTIM) |-> (top_hit != '0), "no way holds the largest RRPV")

endmodule

[tb/sv/ship_rrip_replacement_policy_unit_tb.sv]
module ship_rrip_replacement_policy_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETS         = 1024;
  localparam int unsigned WAYS         = 16;
  localparam int unsigned SHCT_ENTRIES = 16384;
  localparam int unsigned LINES        = SETS * WAYS;
  localparam int unsigned SIG_W        = $clog2(SHCT_ENTRIES);
  localparam int unsigned REQ_W        = $bits(ship_rrip_pkg::req_t);

  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned STREAM_ITEMS = 150;
  localparam int unsigned BURST_ITEMS  = 40;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  ship_rrip_pkg::req_t in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  ship_rrip_pkg::rsp_t out_data_o;

  ship_rrip_replacement_policy_unit #(
    .SETS         (SETS),
    .WAYS         (WAYS),
    .SHCT_ENTRIES (SHCT_ENTRIES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Shadow copy of the policy state
  logic [1:0]       rrpv_mem     [LINES];
  logic [SIG_W-1:0] fill_sig_mem [LINES];
  logic             reused_mem   [LINES];
  logic [1:0]       shct_mem     [SHCT_ENTRIES];

  ship_rrip_pkg::rsp_t expected_rsp_q[$];
  int unsigned         mismatch_cnt = 0;
  int unsigned         items_sent;
  int unsigned         cycle_cnt = 0;

  // Idling controls shared by the test tasks and the response side
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned hold_req_len;
  int unsigned hold_req_tag;

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("ship_rrip_replacement_policy_unit test failed");
      $finish;
    end
  end

  function automatic void clear_shadow_state();
    for (int i = 0; i < LINES; i++) begin
      rrpv_mem[i]     = ship_rrip_pkg::RRPV_DISTANT;
      fill_sig_mem[i] = '0;
      reused_mem[i]   = 1'b0;
    end
    for (int i = 0; i < SHCT_ENTRIES; i++) shct_mem[i] = ship_rrip_pkg::CTR_INIT;
  endfunction

  function automatic logic [SIG_W-1:0] pc_signature(logic [ship_rrip_pkg::PC_W-1:0] pc);
    return SIG_W'(pc % SHCT_ENTRIES);
  endfunction

  // Apply one request to the shadow state and return the response it yields
  function automatic ship_rrip_pkg::rsp_t apply_request(ship_rrip_pkg::req_t r);
    int unsigned         base;
    int unsigned         idx;
    logic [1:0]          top;
    logic [1:0]          ageing;
    logic [SIG_W-1:0]    old_sig;
    logic [SIG_W-1:0]    new_sig;
    bit                  found;
    ship_rrip_pkg::rsp_t rsp;
    base = (int'(r.set_index) % SETS) * WAYS;
    idx  = base + (int'(r.way) % WAYS);
    rsp  = '0;
    if (r.op == ship_rrip_pkg::OP_VICTIM) begin
      // age the set until its largest value is distant, pick lowest such way
      top = ship_rrip_pkg::RRPV_NEAR;
      for (int w = 0; w < WAYS; w++) if (rrpv_mem[base+w] > top) top = rrpv_mem[base+w];
      ageing = ship_rrip_pkg::RRPV_DISTANT - top;
      for (int w = 0; w < WAYS; w++) rrpv_mem[base+w] = rrpv_mem[base+w] + ageing;
      found = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
        if (!found && rrpv_mem[base+w] == ship_rrip_pkg::RRPV_DISTANT) begin
          rsp.victim_way = 4'(w);
          found          = 1'b1;
        end
      end
      rsp.victim_valid = 1'b1;
    end else begin
      old_sig = fill_sig_mem[idx];
      if (r.hit) begin
        rrpv_mem[idx]   = ship_rrip_pkg::RRPV_NEAR;
        reused_mem[idx] = 1'b1;
        if (shct_mem[old_sig] != ship_rrip_pkg::CTR_MAX) begin
          shct_mem[old_sig] = shct_mem[old_sig] + 1;
        end
      end else begin
        // evicted line never reused: train its signature down first
        new_sig = pc_signature(r.pc);
        if (!reused_mem[idx] && shct_mem[old_sig] != ship_rrip_pkg::CTR_ZERO) begin
          shct_mem[old_sig] = shct_mem[old_sig] - 1;
        end
        reused_mem[idx]   = 1'b0;
        fill_sig_mem[idx] = new_sig;
        rrpv_mem[idx]     = (shct_mem[new_sig] == ship_rrip_pkg::CTR_ZERO) ?
                            ship_rrip_pkg::RRPV_DISTANT : ship_rrip_pkg::RRPV_LONG;
      end
    end
    return rsp;
  endfunction

  function automatic ship_rrip_pkg::req_t make_req(logic op, logic [9:0] set_index,
                                                   logic [3:0] way, logic hit,
                                                   logic [ship_rrip_pkg::PC_W-1:0] pc);
    ship_rrip_pkg::req_t r;
    r.op        = op;
    r.set_index = set_index;
    r.way       = way;
    r.hit       = hit;
    r.pc        = pc;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Offer one request; valid stays high so back-to-back items need no toggle
  task automatic send_req(input ship_rrip_pkg::req_t r, output ship_rrip_pkg::rsp_t predicted);
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_request(r);
    expected_rsp_q.push_back(predicted);
    items_sent++;
  endtask

  task automatic send_gap();
    int unsigned n;
    n = tx_idle_en ? pick_gap() : 0;
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_and_gap(input ship_rrip_pkg::req_t r);
    ship_rrip_pkg::rsp_t ignored;
    send_req(r, ignored);
    send_gap();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Response side: compares each transaction, then decides the next stall
  function automatic void check_response(ship_rrip_pkg::rsp_t got);
    ship_rrip_pkg::rsp_t exp;
    if (expected_rsp_q.size() == 0) begin
      $error("response with nothing outstanding: victim_way=%0d victim_valid=%0b",
             got.victim_way, got.victim_valid);
      mismatch_cnt++;
      return;
    end
    exp = expected_rsp_q.pop_front();
    if (got.victim_way !== exp.victim_way) begin
      $error("victim_way: expected %0d, got %0d", exp.victim_way, got.victim_way);
      mismatch_cnt++;
    end
    if (got.victim_valid !== exp.victim_valid) begin
      $error("victim_valid: expected %0b, got %0b", exp.victim_valid, got.victim_valid);
      mismatch_cnt++;
    end
  endfunction

  initial begin : rsp_side
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_response(out_data_o);
      if (hold_req_tag != hold_seen) begin
        hold_seen = hold_req_tag;
        hold_left = hold_req_len;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (!rx_idle_en) begin
        out_stall_i <= 1'b0;
        stall_left  = 0;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        if (stall_left != 0) begin
          out_stall_i <= 1'b1;
          stall_left--;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Fresh state: every line distant, victim is way 0; unused fields ignored
  task automatic test_reset_state();
    send_and_gap(make_req(ship_rrip_pkg::OP_VICTIM, 10'd0, 4'd0, 1'b0, 32'h0000_0000));
    send_and_gap(make_req(ship_rrip_pkg::OP_VICTIM, 10'd1023, 4'd15, 1'b1, 32'hFFFF_FFFF));
  endtask

  // Hits promote the line and train its fill signature up to saturation
  task automatic test_hit_training();
    repeat (3) send_and_gap(make_req(ship_rrip_pkg::OP_UPDATE, 10'd0, 4'd0, 1'b1,
                                     32'h1234_5678));
    send_and_gap(make_req(ship_rrip_pkg::OP_VICTIM, 10'd0, 4'd9, 1'b1, 32'hDEAD_BEEF));
    send_and_gap(make_req(ship_rrip_pkg::OP_UPDATE, 10'd1023, 4'd15, 1'b1, 32'hFFFF_FFFF));
  endtask

  // Fills: reused line skips the penalty, dead line trains down to the floor,
  // and a zero counter inserts distant
  task automatic test_fill_insertion();
    send_and_gap(make_req(ship_rrip_pkg::OP_UPDATE, 10'd0, 4'd0, 1'b0, 32'hFFFF_FFFF));
    repeat (3) send_and_gap(make_req(ship_rrip_pkg::OP_UPDATE, 10'd5, 4'd15, 1'b0,
                                     32'h0000_3FFF));
    send_and_gap(make_req(ship_rrip_pkg::OP_VICTIM, 10'd5, 4'd3, 1'b0, 32'h8000_0000));
    send_and_gap(make_req(ship_rrip_pkg::OP_VICTIM, 10'd0, 4'd0, 1'b0, 32'h0000_0001));
    send_and_gap(make_req(ship_rrip_pkg::OP_UPDATE, 10'd5, 4'd15, 1'b1, 32'h0000_0000));
    send_and_gap(make_req(ship_rrip_pkg::OP_UPDATE, 10'd5, 4'd15, 1'b0, 32'hAAAA_5555));
    send_and_gap(make_req(ship_rrip_pkg::OP_UPDATE, 10'd1023, 4'd8, 1'b0, 32'h5555_AAAA));
    wait_drained();
  endtask

  // One cache access: a hit, a miss (victim then fill of the chosen way),
  // or an arbitrary request as noise
  task automatic run_access(input logic [9:0] hot_set [4], input logic [SIG_W-1:0] sigs [8]);
    logic [9:0]                     set_index;
    logic [ship_rrip_pkg::PC_W-1:0] pc;
    int unsigned                    roll;
    ship_rrip_pkg::rsp_t            victim;
    roll      = $urandom_range(0, 99);
    set_index = ($urandom_range(0, 9) == 0) ? 10'($urandom) : hot_set[$urandom_range(0, 3)];
    pc        = ($urandom() / SHCT_ENTRIES) * SHCT_ENTRIES + sigs[$urandom_range(0, 7)];
    if (roll < 50) begin
      send_and_gap(make_req(ship_rrip_pkg::OP_UPDATE, set_index, 4'($urandom), 1'b1,
                            $urandom()));
    end else if (roll < 90) begin
      send_req(make_req(ship_rrip_pkg::OP_VICTIM, set_index, 4'($urandom), 1'($urandom),
                        $urandom()), victim);
      send_gap();
      send_and_gap(make_req(ship_rrip_pkg::OP_UPDATE, set_index, victim.victim_way, 1'b0, pc));
    end else begin
      send_and_gap(ship_rrip_pkg::req_t'(REQ_W'({$urandom(), $urandom()})));
    end
  endtask

  task automatic run_traffic(input int unsigned n_items);
    logic [9:0]       hot_set [4];
    logic [SIG_W-1:0] sigs    [8];
    int unsigned      stop_at;
    hot_set = '{10'd0, 10'd1023, 10'h155, 10'h2AA};
    sigs[0] = '0;
    sigs[1] = '1;
    for (int i = 2; i < 8; i++) sigs[i] = SIG_W'($urandom);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) run_access(hot_set, sigs);
  endtask

  // Receiver holds off for a long stretch while requests keep coming,
  // then the sender pauses until everything has drained
  task automatic test_backpressure();
    tx_idle_en   = 1'b0;
    hold_req_len = 300;
    hold_req_tag++;
    run_traffic(BURST_ITEMS);
    wait_drained();
  endtask

  // Both sides busy every cycle
  task automatic test_streaming();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_traffic(STREAM_ITEMS);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    run_traffic(RANDOM_ITEMS);
    wait_drained();
  endtask

  initial begin : sequencer
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    items_sent   = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    hold_req_len = 0;
    hold_req_tag = 0;
    clear_shadow_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_hit_training();
    test_fill_insertion();
    test_backpressure();
    test_streaming();
    test_random_traffic();

    // let any late or spurious transaction show up
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("ship_rrip_replacement_policy_unit test passed");
    end else begin
      $display("ship_rrip_replacement_policy_unit test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ship_rrip_pkg.sv
rtl/ship_rrip_line_ram.sv
rtl/ship_rrip_shct_ram.sv
rtl/ship_rrip_sig_hash.sv
rtl/ship_rrip_replacement_policy_unit.sv
tb/sv/ship_rrip_replacement_policy_unit_tb.sv
